/* rtl/core/fconv_pkg.sv */
// Shared types, sizes and opcodes for the full linear convolution core.
`default_nettype none
package fconv_pkg;

    localparam int FIRST_MAX  = 32;
    localparam int SECOND_MAX = 32;
    localparam int DATA_WIDTH = 16;

    localparam int OPCODE_W = 2;
    localparam int VALUE_W  = 16;
    localparam int SUM_W    = 37;
    localparam int POS_W    = 6;

    localparam int FIRST_CW  = $clog2(FIRST_MAX + 1);
    localparam int SECOND_CW = $clog2(SECOND_MAX + 1);
    localparam int FIRST_AW  = (FIRST_MAX > 1) ? $clog2(FIRST_MAX) : 1;
    localparam int SECOND_AW = (SECOND_MAX > 1) ? $clog2(SECOND_MAX) : 1;
    localparam int PROD_W    = 2 * DATA_WIDTH;
    localparam int IDX_W     = POS_W + 2;
    localparam int RAW_W     = (VALUE_W > DATA_WIDTH) ? VALUE_W : DATA_WIDTH;

    localparam logic [OPCODE_W-1:0] OP_LOAD_FIRST  = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_LOAD_SECOND = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_RUN         = 2'd2;

    typedef struct packed {
        logic [OPCODE_W-1:0]      opcode;
        logic signed [VALUE_W-1:0] value;
    } t_item;

    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic [POS_W-1:0]        position;
        logic                    last;
        logic                    overflow;
    } t_result;

    // controller -> datapath
    typedef struct packed {
        logic                 load_first;
        logic                 load_second;
        logic                 run;
        logic                 issue;
        logic                 term_ok;
        logic [FIRST_AW-1:0]  lhs_addr;
        logic [SECOND_AW-1:0] rhs_addr;
        logic                 emit;
        logic [POS_W-1:0]     position;
        logic                 last;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic [FIRST_CW-1:0]  first_count;
        logic [SECOND_CW-1:0] second_count;
    } t_stat;

    // Low DATA_WIDTH bits of the load word, sign taken from bit DATA_WIDTH-1.
    function automatic logic [DATA_WIDTH-1:0] widen(input logic [VALUE_W-1:0] value);
        logic [RAW_W-1:0] raw;
        raw = '0;
        raw[VALUE_W-1:0] = value;
        return raw[DATA_WIDTH-1:0];
    endfunction

endpackage
`default_nettype wire

/* rtl/core/fconv_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module fconv_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

/* rtl/core/fconv_ctrl.sv */
// Sequencer: decodes commands and steps the sample and tap loops of a run.
`default_nettype none
module fconv_ctrl import fconv_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire logic [OPCODE_W-1:0] i_opcode,
    input  wire t_stat               i_stat,
    output logic                     o_busy,
    output t_cmd                     o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MAC  = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]           r_state, n_state;
    logic [FIRST_CW-1:0]  r_len_l, n_len_l;
    logic [SECOND_CW-1:0] r_len_r, n_len_r;
    logic [POS_W-1:0]     r_k, n_k;
    logic [POS_W-1:0]     r_last_k, n_last_k;
    logic [SECOND_CW-1:0] r_i, n_i;
    logic                 r_wait, n_wait;

    logic                 accept;
    logic [IDX_W-1:0]     total;
    logic [IDX_W-1:0]     idx;
    logic                 tap_last;
    logic                 k_last;

    assign o_busy = (r_state != ST_IDLE);
    assign accept = i_start && !o_busy;

    assign total = IDX_W'(i_stat.first_count) + IDX_W'(i_stat.second_count);
    // lhs index of the current tap; negative when the tap hangs off the front
    assign idx = IDX_W'(r_k) + IDX_W'(r_i) + IDX_W'(1) - IDX_W'(r_len_r);
    assign tap_last = (r_i + SECOND_CW'(1)) == r_len_r;
    assign k_last = (r_k == r_last_k);

    always_comb begin
        o_cmd             = '0;
        o_cmd.load_first  = accept && (i_opcode == OP_LOAD_FIRST);
        o_cmd.load_second = accept && (i_opcode == OP_LOAD_SECOND);
        o_cmd.run         = accept && (i_opcode == OP_RUN);
        o_cmd.issue       = (r_state == ST_MAC);
        o_cmd.term_ok     = !idx[IDX_W-1] && (idx < IDX_W'(r_len_l));
        o_cmd.lhs_addr    = idx[FIRST_AW-1:0];
        o_cmd.rhs_addr    = r_i[SECOND_AW-1:0];
        o_cmd.emit        = (r_state == ST_EMIT);
        o_cmd.position    = r_k;
        o_cmd.last        = k_last;
    end

    always_comb begin
        n_state  = r_state;
        n_len_l  = r_len_l;
        n_len_r  = r_len_r;
        n_k      = r_k;
        n_last_k = r_last_k;
        n_i      = r_i;
        n_wait   = r_wait;
        case (r_state)
            ST_IDLE: begin
                if (o_cmd.run) begin
                    n_len_l  = i_stat.first_count;
                    n_len_r  = i_stat.second_count;
                    n_k      = '0;
                    n_i      = '0;
                    n_last_k = POS_W'(total - IDX_W'(2));
                    if (total >= IDX_W'(2)) begin
                        n_state = (i_stat.second_count == '0) ? ST_EMIT : ST_MAC;
                    end
                end
            end
            ST_MAC: begin
                n_i = r_i + SECOND_CW'(1);
                if (tap_last) begin
                    n_state = ST_WAIT;
                    n_wait  = 1'b0;
                end
            end
            ST_WAIT: begin
                // wait for the read and multiply stages to drain
                n_wait = 1'b1;
                if (r_wait) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                n_k = r_k + POS_W'(1);
                n_i = '0;
                if (k_last) begin
                    n_state = ST_IDLE;
                end else begin
                    n_state = (r_len_r == '0) ? ST_EMIT : ST_MAC;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_len_l  <= '0;
            r_len_r  <= '0;
            r_k      <= '0;
            r_last_k <= '0;
            r_i      <= '0;
            r_wait   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_len_l  <= n_len_l;
            r_len_r  <= n_len_r;
            r_k      <= n_k;
            r_last_k <= n_last_k;
            r_i      <= n_i;
            r_wait   <= n_wait;
        end
    end

endmodule
`default_nettype wire

/* rtl/core/fconv_dp.sv */
// Datapath: element stores, fill counts, overflow flag and the shared MAC.
`default_nettype none
module fconv_dp import fconv_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic [VALUE_W-1:0] i_value,
    input  wire t_cmd               i_cmd,
    output t_stat                   o_stat,
    output logic                    o_strobe,
    output t_result                 o_result
);

    logic [FIRST_CW-1:0]   r_first_cnt, n_first_cnt;
    logic [SECOND_CW-1:0]  r_second_cnt, n_second_cnt;
    logic                  r_ovf, n_ovf;
    logic                  r_ovf_snap, n_ovf_snap;
    logic                  r_v1, r_v2;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [SUM_W-1:0]  r_acc;
    logic                  r_strobe;
    t_result               r_result;

    logic                  first_we, second_we;
    logic [DATA_WIDTH-1:0] elem;
    logic [DATA_WIDTH-1:0] lhs_q, rhs_q;

    assign elem      = widen(i_value);
    assign first_we  = i_cmd.load_first && (r_first_cnt < FIRST_CW'(FIRST_MAX));
    assign second_we = i_cmd.load_second && (r_second_cnt < SECOND_CW'(SECOND_MAX));

    fconv_ram #(.WIDTH(DATA_WIDTH), .DEPTH(FIRST_MAX)) u_first_ram (
        .i_clk   (i_clk),
        .i_we    (first_we),
        .i_waddr (r_first_cnt[FIRST_AW-1:0]),
        .i_wdata (elem),
        .i_raddr (i_cmd.lhs_addr),
        .o_rdata (lhs_q)
    );

    fconv_ram #(.WIDTH(DATA_WIDTH), .DEPTH(SECOND_MAX)) u_second_ram (
        .i_clk   (i_clk),
        .i_we    (second_we),
        .i_waddr (r_second_cnt[SECOND_AW-1:0]),
        .i_wdata (elem),
        .i_raddr (i_cmd.rhs_addr),
        .o_rdata (rhs_q)
    );

    always_comb begin
        n_first_cnt  = r_first_cnt;
        n_second_cnt = r_second_cnt;
        n_ovf        = r_ovf;
        n_ovf_snap   = r_ovf_snap;
        if (first_we) begin
            n_first_cnt = r_first_cnt + FIRST_CW'(1);
        end
        if (second_we) begin
            n_second_cnt = r_second_cnt + SECOND_CW'(1);
        end
        if ((i_cmd.load_first && !first_we) || (i_cmd.load_second && !second_we)) begin
            n_ovf = 1'b1;
        end
        if (i_cmd.run) begin
            n_first_cnt  = '0;
            n_second_cnt = '0;
            n_ovf        = 1'b0;
            n_ovf_snap   = r_ovf;
        end
    end

    assign o_stat.first_count  = r_first_cnt;
    assign o_stat.second_count = r_second_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_cnt  <= '0;
            r_second_cnt <= '0;
            r_ovf        <= 1'b0;
            r_ovf_snap   <= 1'b0;
            r_v1         <= 1'b0;
            r_v2         <= 1'b0;
            r_strobe     <= 1'b0;
            r_acc        <= '0;
        end else begin
            r_first_cnt  <= n_first_cnt;
            r_second_cnt <= n_second_cnt;
            r_ovf        <= n_ovf;
            r_ovf_snap   <= n_ovf_snap;
            // read, multiply, accumulate; taps outside lhs carry no valid
            r_v1         <= i_cmd.issue && i_cmd.term_ok;
            r_v2         <= r_v1;
            r_strobe     <= i_cmd.emit;
            if (i_cmd.run || i_cmd.emit) begin
                r_acc <= '0;
            end else if (r_v2) begin
                r_acc <= r_acc + SUM_W'(r_prod);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= $signed(lhs_q) * $signed(rhs_q);
        if (i_cmd.emit) begin
            r_result.sum      <= r_acc;
            r_result.position <= i_cmd.position;
            r_result.last     <= i_cmd.last;
            r_result.overflow <= r_ovf_snap;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule
`default_nettype wire

/* rtl/core/full_linear_convolution_core.sv */
// Top level of the full linear convolution core.
`default_nettype none
// Loads (opcode 0 first vector, 1 second vector) are taken whenever busy is low;
// a load into a full vector is dropped and sets the overflow flag. A run
// (opcode 2) emits first_len+second_len-1 words on o_result, each marked by a
// one-cycle o_strobe that cannot be held off, and clears both lengths and the
// flag. Each sample runs second_len taps through one multiply-accumulate
// unit, fed by the two element RAMs at one read each per cycle, then waits
// for the read and multiply stages to drain before its word is emitted (with
// an empty second vector each sample goes straight to emit). Busy stays high
// from the run word until the last word is emitted; the last word is on
// o_result in the first cycle with busy low.
module full_linear_convolution_core import fconv_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  start,
    input  wire t_item i_item,
    output logic       busy,
    output logic       o_strobe,
    output t_result    o_result
);

    t_cmd  cmd;
    t_stat stat;

    fconv_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_opcode (i_item.opcode),
        .i_stat   (stat),
        .o_busy   (busy),
        .o_cmd    (cmd)
    );

    fconv_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_value  (i_item.value),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

`ifndef SYNTHESIS
    a_word_from_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result word without a run in progress");

    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.last) |-> !busy)
        else $error("still busy after the final word");

    a_more_to_come: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.last) |-> busy)
        else $error("run ended before its final word");
`endif

endmodule
`default_nettype wire

/* tb/full_linear_convolution_core_test.sv */
// Self-checking testbench for the full linear convolution core: directed table, then random load/run sequences.
module full_linear_convolution_core_test;
    timeunit 1ns;
    timeprecision 1ps;
    import fconv_pkg::*;

    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 64;
    localparam int RANDOM_WORDS = 80;
    localparam int MAX_GAP      = 8;
    localparam int PHASE_WORDS  = 12;
    localparam int PRINT_CAP    = 40;

    // typed: -1 take the predictor, 0 no word, 1 one word (position 0, last, no overflow)
    typedef struct {
        t_item  word;
        int     typed;
        longint sum;
    } t_plan_row;

    logic    i_clk;
    logic    i_rst_n;
    logic    start;
    t_item   i_item;
    logic    busy;
    logic    o_strobe;
    t_result o_result;

    // predictor state
    logic signed [DATA_WIDTH-1:0] lhs_mem [FIRST_MAX];
    logic signed [DATA_WIDTH-1:0] rhs_mem [SECOND_MAX];
    int      lhs_len;
    int      rhs_len;
    bit      drop_seen;
    t_result sample_q [$];

    t_plan_row plan [$];
    t_result   got_want;
    int        error_count;
    int        cycle_count;
    int        words_sent;

    full_linear_convolution_core dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic note_mismatch(input string msg);
        if (error_count < PRINT_CAP)
            $display("%0t mismatch: %s", $time, msg);
        error_count++;
    endtask

    // Advance the model by one accepted word; when keep is set, queue the samples a run yields.
    task automatic convolve_word(input t_item w, input bit keep);
        logic signed [DATA_WIDTH-1:0] elem;
        longint  acc;
        int      n;
        int      k;
        int      i;
        int      idx;
        t_result r;
        elem = w.value[DATA_WIDTH-1:0];
        case (w.opcode)
            OP_LOAD_FIRST: begin
                if (lhs_len < FIRST_MAX) begin
                    lhs_mem[lhs_len] = elem;
                    lhs_len++;
                end else begin
                    drop_seen = 1'b1;
                end
            end
            OP_LOAD_SECOND: begin
                if (rhs_len < SECOND_MAX) begin
                    rhs_mem[rhs_len] = elem;
                    rhs_len++;
                end else begin
                    drop_seen = 1'b1;
                end
            end
            OP_RUN: begin
                n = lhs_len + rhs_len - 1;
                for (k = 0; k < n; k++) begin
                    acc = 0;
                    for (i = 0; i < rhs_len; i++) begin
                        idx = k - rhs_len + 1 + i;
                        if (idx >= 0 && idx < lhs_len)
                            acc += longint'(lhs_mem[idx]) * longint'(rhs_mem[i]);
                    end
                    r.sum      = acc[SUM_W-1:0];
                    r.position = k[POS_W-1:0];
                    r.last     = (k == n - 1);
                    r.overflow = drop_seen;
                    if (keep)
                        sample_q.push_back(r);
                end
                lhs_len   = 0;
                rhs_len   = 0;
                drop_seen = 1'b0;
            end
            default: ;
        endcase
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        logic [31:0] raw;
        raw = $urandom;
        case ($urandom_range(7))
            0:       return {1'b0, {(VALUE_W-1){1'b1}}};
            1:       return {1'b1, {(VALUE_W-1){1'b0}}};
            default: return raw[VALUE_W-1:0];
        endcase
    endfunction

    // Entered and left at a falling edge. Sender gaps depend on the phase.
    task automatic drive_word(input t_item w, input int typed, input longint want_sum);
        int      idle_pct;
        int      gap;
        t_item   junk;
        t_result r;
        case ((words_sent / PHASE_WORDS) % 4)
            1:       idle_pct = 66;
            3:       idle_pct = 10;
            default: idle_pct = 0;
        endcase
        words_sent++;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0) begin
            junk.opcode = OPCODE_W'($urandom_range(3));
            junk.value  = pick_value();
            start  <= 1'b0;
            i_item <= junk;
            repeat (gap) @(negedge i_clk);
        end
        start  <= 1'b1;
        i_item <= w;
        do @(posedge i_clk); while (busy);
        convolve_word(w, typed < 0);
        if (typed == 1) begin
            r.sum      = want_sum[SUM_W-1:0];
            r.position = '0;
            r.last     = 1'b1;
            r.overflow = 1'b0;
            sample_q.push_back(r);
        end
        @(negedge i_clk);
    endtask

    task automatic send_op(input logic [OPCODE_W-1:0] op);
        t_item w;
        w.opcode = op;
        w.value  = pick_value();
        drive_word(w, -1, 0);
    endtask

    function automatic void add_row(input logic [OPCODE_W-1:0] op, input logic [VALUE_W-1:0] val,
                                    input int typed, input longint sum);
        t_plan_row row;
        row.word.opcode = op;
        row.word.value  = val;
        row.typed       = typed;
        row.sum         = sum;
        plan.push_back(row);
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe !== 1'b0) begin
            if (sample_q.size() == 0) begin
                note_mismatch($sformatf("unexpected word, position %0d", o_result.position));
            end else begin
                got_want = sample_q.pop_front();
                if (o_result.sum !== got_want.sum)
                    note_mismatch($sformatf("sum at position %0d: got %0d want %0d",
                                            got_want.position, o_result.sum, got_want.sum));
                if (o_result.position !== got_want.position)
                    note_mismatch($sformatf("position: got %0d want %0d",
                                            o_result.position, got_want.position));
                if (o_result.last !== got_want.last)
                    note_mismatch($sformatf("last at position %0d: got %b want %b",
                                            got_want.position, o_result.last, got_want.last));
                if (o_result.overflow !== got_want.overflow)
                    note_mismatch($sformatf("overflow at position %0d: got %b want %b",
                                            got_want.position, o_result.overflow,
                                            got_want.overflow));
            end
        end
    end

    initial begin
        int random_words;
        int want_l;
        int want_r;
        int got_l;
        int got_r;
        bit big_done;

        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_item      = '0;
        lhs_len     = 0;
        rhs_len     = 0;
        drop_seen   = 1'b0;
        error_count = 0;
        cycle_count = 0;
        words_sent  = 0;

        // empty run right after reset, then products at the value extremes
        add_row(OP_RUN,         16'h0000, 0, 0);
        add_row(OP_LOAD_FIRST,  16'h7FFF, 0, 0);
        add_row(OP_LOAD_SECOND, 16'h7FFF, 0, 0);
        add_row(OP_RUN,         16'h8001, 1, 64'sd1073676289);
        add_row(OP_LOAD_FIRST,  16'h8000, 0, 0);
        add_row(OP_LOAD_SECOND, 16'h8000, 0, 0);
        add_row(OP_RUN,         16'hFFFF, 1, 64'sd1073741824);
        add_row(OP_LOAD_FIRST,  16'h8000, 0, 0);
        add_row(OP_LOAD_SECOND, 16'h7FFF, 0, 0);
        add_row(OP_RUN,         16'h0000, 1, -64'sd1073709056);
        // second vector empty: one zero sample per extra first element
        add_row(OP_LOAD_FIRST,  16'h0005, 0, 0);
        add_row(OP_LOAD_FIRST,  16'hFFFD, 0, 0);
        add_row(OP_RUN,         16'h0000, 1, 0);
        // a single element on one side only gives nothing
        add_row(OP_LOAD_SECOND, 16'h0007, 0, 0);
        add_row(OP_RUN,         16'h0000, 0, 0);
        add_row(OP_UNUSED,      16'hFFFF, 0, 0);
        add_row(OP_LOAD_FIRST,  16'h0001, -1, 0);
        add_row(OP_LOAD_FIRST,  16'h0002, -1, 0);
        add_row(OP_UNUSED,      16'h1234, -1, 0);
        add_row(OP_LOAD_SECOND, 16'h0003, -1, 0);
        add_row(OP_LOAD_SECOND, 16'h0004, -1, 0);
        add_row(OP_RUN,         16'h5A5A, -1, 0);

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[j])
            drive_word(plan[j].word, plan[j].typed, plan[j].sum);

        // First sequence fills both vectors and drops one load; the rest are mostly short, now and then longer.
        random_words = 0;
        big_done     = 1'b0;
        while (random_words < RANDOM_WORDS) begin
            if (!big_done) begin
                want_l   = FIRST_MAX + 1;
                want_r   = SECOND_MAX;
                big_done = 1'b1;
            end else if ($urandom_range(11) == 0) begin
                want_l = $urandom_range(FIRST_MAX);
                want_r = $urandom_range(SECOND_MAX / 2);
            end else begin
                want_l = $urandom_range(6);
                want_r = $urandom_range(6);
            end
            got_l = 0;
            got_r = 0;
            while (got_l < want_l || got_r < want_r) begin
                if ($urandom_range(15) == 0) begin
                    send_op(OP_UNUSED);
                end else if (got_r >= want_r || (got_l < want_l && $urandom_range(1) == 1)) begin
                    send_op(OP_LOAD_FIRST);
                    got_l++;
                    random_words++;
                end else begin
                    send_op(OP_LOAD_SECOND);
                    got_r++;
                    random_words++;
                end
            end
            // now and then skip the run so loads pile up into the next sequence
            if ($urandom_range(9) != 0) begin
                send_op(OP_RUN);
                random_words++;
            end
        end
        send_op(OP_RUN);
        start <= 1'b0;

        while (sample_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

/* full_linear_convolution_core.f */
rtl/core/fconv_pkg.sv
rtl/core/fconv_ram.sv
rtl/core/fconv_ctrl.sv
rtl/core/fconv_dp.sv
rtl/core/full_linear_convolution_core.sv
tb/full_linear_convolution_core_test.sv
